>>> hw/rtl/npc_pkg.sv
// Shared types, codes and helpers for the nearest palette color block.
package npc_pkg;

    localparam int CH_W   = 8;
    localparam int IDX_W  = 5;
    localparam int DIST_W = 18;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int SQ_W   = 2 * CH_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_MIX   = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_FOUND     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNWRITTEN = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_SEARCH,
        S_FLUSH
    } fsm_state_t;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // palette write broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        rgb_t             color;
    } wr_t;

    // token that walks the cell chain
    typedef struct packed {
        logic              valid;
        logic              gather;  // 1: collect mix operands, 0: distance search
        rgb_t              color;
        logic              any;
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  idx_a;
        logic [IDX_W-1:0]  idx_b;
        rgb_t              col_a;
        rgb_t              col_b;
        logic              ok_a;
        logic              ok_b;
    } token_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

>>> hw/rtl/npc_cell.sv
// One chain cell: holds a palette entry and updates the passing token.
module npc_cell #(
    parameter int CELL_ID = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  npc_pkg::wr_t   wr,
    input  npc_pkg::token_t tok_in,
    output npc_pkg::token_t tok_out
);
    import npc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    rgb_t              entry_reg;
    logic              entry_vld_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              tok_vld_reg;
    logic              wr_hit;
    logic [DIST_W-1:0] cand_dist;

    assign wr_hit = wr.en && (int'(wr.idx) == CELL_ID);

    assign cand_dist = DIST_W'(sq_diff(entry_reg.r, tok_in.color.r))
                     + DIST_W'(sq_diff(entry_reg.g, tok_in.color.g))
                     + DIST_W'(sq_diff(entry_reg.b, tok_in.color.b));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.gather)
        begin
            if (entry_vld_reg && (int'(tok_in.idx_a) == CELL_ID))
            begin
                tok_next.col_a = entry_reg;
                tok_next.ok_a  = 1'b1;
            end
            if (entry_vld_reg && (int'(tok_in.idx_b) == CELL_ID))
            begin
                tok_next.col_b = entry_reg;
                tok_next.ok_b  = 1'b1;
            end
        end
        else if (entry_vld_reg && (!tok_in.any || (cand_dist < tok_in.sq_dist)))
        begin
            // strict compare: an earlier (lower) index keeps a tie
            tok_next.any     = 1'b1;
            tok_next.sq_dist = cand_dist;
            tok_next.idx     = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= 1'b0;
            tok_vld_reg   <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                entry_vld_reg <= 1'b1;
            end
            tok_vld_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            entry_reg <= wr.color;
        end
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_vld_reg;
    end

endmodule

>>> hw/rtl/nearest_palette_color.sv
// Top level: nearest palette color search over a chain of palette cells.
//
// Input channel (in_valid/in_ready) takes one op per transfer:
//   write  - stores red/green/blue at entry_index; no result.
//   query  - searches the palette for the given color.
//   mix    - averages entries entry_index and second_index (floor per channel)
//            and searches for that color.
// Output channel (out_valid/out_ready) returns status, the searched color,
// the nearest entry index and its squared distance.
// Each palette entry lives in its own cell; a search token walks the chain,
// one cell per cycle. A query needs one pass, a mix needs two (operand
// gather, then search); a mix with an unwritten operand skips the search.
// One item is worked on at a time. The output register parts the two sides:
// a finished result waits there while the next item is accepted; a further
// result waits in the result holding register until the receiver takes it.
// Reset clears every entry's valid mark, the chain and both channels.
module nearest_palette_color #(
    parameter int PALETTE_SIZE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [npc_pkg::OP_W-1:0]      op,
    input  logic [npc_pkg::IDX_W-1:0]     entry_index,
    input  logic [npc_pkg::IDX_W-1:0]     second_index,
    input  logic [npc_pkg::CH_W-1:0]      red,
    input  logic [npc_pkg::CH_W-1:0]      green,
    input  logic [npc_pkg::CH_W-1:0]      blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [npc_pkg::STAT_W-1:0]    status,
    output logic [npc_pkg::CH_W-1:0]      searched_red,
    output logic [npc_pkg::CH_W-1:0]      searched_green,
    output logic [npc_pkg::CH_W-1:0]      searched_blue,
    output logic [npc_pkg::IDX_W-1:0]     nearest_index,
    output logic [npc_pkg::DIST_W-1:0]    best_distance
);
    import npc_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    token_t chain [PALETTE_SIZE+1];
    token_t tail;
    token_t head;
    wr_t    wr;
    rgb_t   mix_avg;
    logic   in_xfer;
    logic   slot_free;
    logic   res_load;
    logic   out_load;

    // result holding register
    logic [STAT_W-1:0] res_status_reg;
    logic [STAT_W-1:0] res_status_next;
    rgb_t              res_color_reg;
    rgb_t              res_color_next;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [IDX_W-1:0]  res_idx_next;
    logic [DIST_W-1:0] res_dist_reg;
    logic [DIST_W-1:0] res_dist_next;

    // output register
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    rgb_t              out_color_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [DIST_W-1:0] out_dist_reg;

    // ---------------------------------------------------------------- chain
    assign chain[0] = head;
    assign tail     = chain[PALETTE_SIZE];

    for (genvar i = 0; i < PALETTE_SIZE; i++)
    begin : g_cell
        npc_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // ------------------------------------------------------- input handling
    assign in_xfer = in_valid && in_ready;

    // writes go straight to the addressed cell; out-of-range indexes hit none
    always_comb
    begin
        wr.en      = in_xfer && (op == OP_WRITE);
        wr.idx     = entry_index;
        wr.color.r = red;
        wr.color.g = green;
        wr.color.b = blue;
    end

    // floor average of the two gathered mix operands
    always_comb
    begin
        logic [CH_W:0] sr;
        logic [CH_W:0] sg;
        logic [CH_W:0] sb;
        sr = {1'b0, tail.col_a.r} + {1'b0, tail.col_b.r};
        sg = {1'b0, tail.col_a.g} + {1'b0, tail.col_b.g};
        sb = {1'b0, tail.col_a.b} + {1'b0, tail.col_b.b};
        mix_avg.r = sr[CH_W:1];
        mix_avg.g = sg[CH_W:1];
        mix_avg.b = sb[CH_W:1];
    end

    assign slot_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (op == OP_QUERY))
                begin
                    state_next = S_SEARCH;
                end
                else if (in_xfer && (op == OP_MIX))
                begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER:
            begin
                if (tail.valid)
                begin
                    state_next = (tail.ok_a && tail.ok_b) ? S_SEARCH : S_FLUSH;
                end
            end
            S_SEARCH:
            begin
                if (tail.valid)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        head            = '0;
        res_load        = 1'b0;
        out_load        = 1'b0;
        res_status_next = STAT_FOUND;
        res_color_next  = tail.color;
        res_idx_next    = tail.idx;
        res_dist_next   = tail.sq_dist;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                head.color.r   = red;
                head.color.g   = green;
                head.color.b   = blue;
                head.idx_a     = entry_index;
                head.idx_b     = second_index;
                head.gather    = (op == OP_MIX);
                head.valid     = in_valid && ((op == OP_QUERY) || (op == OP_MIX));
            end
            S_GATHER:
            begin
                if (tail.ok_a && tail.ok_b)
                begin
                    head.valid = tail.valid;
                    head.color = mix_avg;
                end
                else
                begin
                    // an operand never written: all-zero result
                    res_load        = tail.valid;
                    res_status_next = STAT_UNWRITTEN;
                    res_color_next  = '0;
                    res_idx_next    = '0;
                    res_dist_next   = '0;
                end
            end
            S_SEARCH:
            begin
                res_load        = tail.valid;
                res_status_next = tail.any ? STAT_FOUND : STAT_EMPTY;
            end
            S_FLUSH:
            begin
                out_load = slot_free;
            end
        endcase
    end

    // ----------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_color_reg  <= res_color_next;
            res_idx_reg    <= res_idx_next;
            res_dist_reg   <= res_dist_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_color_reg  <= res_color_reg;
            out_idx_reg    <= res_idx_reg;
            out_dist_reg   <= res_dist_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign searched_red   = out_color_reg.r;
    assign searched_green = out_color_reg.g;
    assign searched_blue  = out_color_reg.b;
    assign nearest_index  = out_idx_reg;
    assign best_distance  = out_dist_reg;

    // ----------------------------------------------------------- checks
`ifndef ASSERT_OFF
    logic [PALETTE_SIZE-1:0] tok_vld;

    for (genvar k = 0; k < PALETTE_SIZE; k++)
    begin : g_vld
        assign tok_vld[k] = chain[k+1].valid;
    end

    // at most one token travels the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell chain");

    // a token only leaves the chain while a pass is expected
    a_tail_state: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == S_GATHER || state_reg == S_SEARCH))
        else $error("token left the chain outside a pass");

    // an unwritten mix operand gives an all-zero result
    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_UNWRITTEN) |->
            (best_distance == '0 && nearest_index == '0 &&
             searched_red == '0 && searched_green == '0 && searched_blue == '0))
        else $error("unwritten-entry result carries nonzero fields");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for nearest_palette_color: op stream, palette search model, answer check.

// One search answer as the block presents it on its output channel.
typedef struct packed {
    logic [npc_pkg::STAT_W-1:0] status;
    npc_pkg::rgb_t              color;
    logic [npc_pkg::IDX_W-1:0]  idx;
    logic [npc_pkg::DIST_W-1:0] sq_dist;
} palette_answer_t;

class nearest_color_checker;
    localparam int ENTRIES = 32;

    npc_pkg::rgb_t   palette_colors [ENTRIES];
    bit              palette_written[ENTRIES];
    palette_answer_t pending_answers[$];
    int              fail_count;

    function new();
        for (int i = 0; i < ENTRIES; i++) begin
            palette_colors[i]  = '0;
            palette_written[i] = 1'b0;
        end
        fail_count = 0;
    endfunction

    function automatic int chan_dist(input int a, input int b);
        int d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    // Scan valid entries in index order; strict less-than keeps the lowest index on ties.
    function automatic palette_answer_t find_nearest(input npc_pkg::rgb_t c);
        palette_answer_t ans;
        bit              any;
        int              best;
        int              best_idx;
        int              d;
        any      = 1'b0;
        best     = 0;
        best_idx = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (palette_written[i]) begin
                d = chan_dist(palette_colors[i].r, c.r) + chan_dist(palette_colors[i].g, c.g)
                    + chan_dist(palette_colors[i].b, c.b);
                if (!any || d < best) begin
                    any      = 1'b1;
                    best     = d;
                    best_idx = i;
                end
            end
        end
        ans.status  = any ? npc_pkg::STAT_FOUND : npc_pkg::STAT_EMPTY;
        ans.color   = c;
        ans.idx     = best_idx[npc_pkg::IDX_W-1:0];
        ans.sq_dist = best[npc_pkg::DIST_W-1:0];
        return ans;
    endfunction

    // Update the palette copy for one accepted op and queue its answer, if any.
    function void note_op(input logic [1:0] op, input logic [4:0] ia, input logic [4:0] ib,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        npc_pkg::rgb_t   c;
        palette_answer_t ans;
        case (op)
            npc_pkg::OP_WRITE:
            begin
                palette_colors[ia]  = '{r: r, g: g, b: b};
                palette_written[ia] = 1'b1;
            end
            npc_pkg::OP_QUERY:
            begin
                c = '{r: r, g: g, b: b};
                pending_answers.push_back(find_nearest(c));
            end
            npc_pkg::OP_MIX:
            begin
                if (!palette_written[ia] || !palette_written[ib]) begin
                    ans        = '0;
                    ans.status = npc_pkg::STAT_UNWRITTEN;
                    pending_answers.push_back(ans);
                end
                else begin
                    c.r = 8'((9'(palette_colors[ia].r) + 9'(palette_colors[ib].r)) >> 1);
                    c.g = 8'((9'(palette_colors[ia].g) + 9'(palette_colors[ib].g)) >> 1);
                    c.b = 8'((9'(palette_colors[ia].b) + 9'(palette_colors[ib].b)) >> 1);
                    pending_answers.push_back(find_nearest(c));
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    function void check_answer(input palette_answer_t got);
        palette_answer_t want;
        if (pending_answers.size() == 0) begin
            $error("answer with none pending: status %0d idx %0d dist %0d",
                   got.status, got.idx, got.sq_dist);
            fail_count++;
            return;
        end
        want = pending_answers.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("searched_red", want.color.r, got.color.r);
        compare_field("searched_green", want.color.g, got.color.g);
        compare_field("searched_blue", want.color.b, got.color.b);
        compare_field("nearest_index", want.idx, got.idx);
        compare_field("best_distance", want.sq_dist, got.sq_dist);
    endfunction
endclass

module tb;
    import npc_pkg::*;

    localparam int PALETTE_SIZE  = 32;
    localparam int RANDOM_OPS    = 1750;
    // Longest legal run without any transfer: a mix pass plus sender
    // gaps and receiver stalls; this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // Enough cycles after the last answer for a stray one to show up.
    localparam int DRAIN_CYCLES  = 2 * PALETTE_SIZE + 16;
    // op code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op           = OP_WRITE;
    logic [IDX_W-1:0]  entry_index  = '0;
    logic [IDX_W-1:0]  second_index = '0;
    logic [CH_W-1:0]   red          = '0;
    logic [CH_W-1:0]   green        = '0;
    logic [CH_W-1:0]   blue         = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [STAT_W-1:0] status;
    logic [CH_W-1:0]   searched_red;
    logic [CH_W-1:0]   searched_green;
    logic [CH_W-1:0]   searched_blue;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] best_distance;

    // Set during the long stretch where neither side idles.
    logic quiet_stretch = 1'b0;
    int   idle_cycles   = 0;

    nearest_color_checker palette_model = new();

    nearest_palette_color #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .entry_index   (entry_index),
        .second_index  (second_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .searched_red  (searched_red),
        .searched_green(searched_green),
        .searched_blue (searched_blue),
        .nearest_index (nearest_index),
        .best_distance (best_distance)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: checks every output transfer, stalls ~15% of cycles outside the quiet stretch.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            palette_model.check_answer('{status: status,
                                         color: '{r: searched_red, g: searched_green,
                                                  b: searched_blue},
                                         idx: nearest_index, sq_dist: best_distance});
        out_ready <= quiet_stretch || ($urandom_range(99) >= 15);
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Drive one op and wait for its input transfer. Valid drops only when a gap
    // is taken, so back-to-back ops keep valid high with a single assignment.
    task automatic push_palette_op(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] ia,
                                   input logic [IDX_W-1:0] ib, input logic [CH_W-1:0] r,
                                   input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        if (!quiet_stretch && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        entry_index  <= ia;
        second_index <= ib;
        red          <= r;
        green        <= g;
        blue         <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        palette_model.note_op(o, ia, ib, r, g, b);
    endtask

    // Prefer an index that already holds a color, so mixes get past the written check.
    function automatic logic [IDX_W-1:0] pick_written_entry();
        int k;
        for (int tries = 0; tries < 64; tries++) begin
            k = $urandom_range(PALETTE_SIZE - 1);
            if (palette_model.palette_written[k])
                return k[IDX_W-1:0];
        end
        return IDX_W'($urandom_range(PALETTE_SIZE - 1));
    endfunction

    // Channel value biased toward the extremes now and then.
    function automatic logic [CH_W-1:0] pick_channel();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return CH_W'($urandom_range(255));
    endfunction

    initial
    begin
        int            sel;
        int            k;
        logic [IDX_W-1:0] ia;
        logic [IDX_W-1:0] ib;
        rgb_t          c;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // empty palette: status empty, searched color echoed
        push_palette_op(OP_QUERY, 5'd0, 5'd0, 8'd1, 8'd2, 8'd3);
        // mix of entries never written
        push_palette_op(OP_MIX, 5'd0, 5'd31, 8'hff, 8'hff, 8'hff);
        // unused op code: must neither write nor answer
        push_palette_op(OP_UNUSED, 5'd0, 5'd0, 8'h40, 8'h40, 8'h40);
        push_palette_op(OP_WRITE, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00);
        // largest possible distance
        push_palette_op(OP_QUERY, 5'd31, 5'd31, 8'hff, 8'hff, 8'hff);
        push_palette_op(OP_WRITE, 5'd31, 5'd0, 8'hff, 8'hff, 8'hff);
        push_palette_op(OP_QUERY, 5'd0, 5'd0, 8'h80, 8'h80, 8'h80);
        push_palette_op(OP_QUERY, 5'd0, 5'd0, 8'h7f, 8'h7f, 8'h7f);
        // floor average of black and white
        push_palette_op(OP_MIX, 5'd0, 5'd31, 8'h00, 8'h00, 8'h00);
        push_palette_op(OP_MIX, 5'd31, 5'd31, 8'h00, 8'h00, 8'h00);
        // one side written, other not
        push_palette_op(OP_MIX, 5'd0, 5'd5, 8'h00, 8'h00, 8'h00);
        push_palette_op(OP_MIX, 5'd5, 5'd31, 8'h00, 8'h00, 8'h00);
        // equal distances: lowest index wins
        push_palette_op(OP_WRITE, 5'd7, 5'd0, 8'h12, 8'h34, 8'h56);
        push_palette_op(OP_WRITE, 5'd2, 5'd0, 8'h12, 8'h34, 8'h56);
        push_palette_op(OP_QUERY, 5'd0, 5'd0, 8'h12, 8'h34, 8'h56);
        // overwrite of an existing entry
        push_palette_op(OP_WRITE, 5'd0, 5'd0, 8'h12, 8'h34, 8'h56);
        push_palette_op(OP_QUERY, 5'd0, 5'd0, 8'h12, 8'h34, 8'h56);
        push_palette_op(OP_UNUSED, 5'd31, 5'd10, 8'h00, 8'h00, 8'h00);
        push_palette_op(OP_WRITE, 5'd21, 5'd10, 8'h55, 8'haa, 8'h55);
        push_palette_op(OP_QUERY, 5'd10, 5'd21, 8'haa, 8'h55, 8'haa);
        push_palette_op(OP_MIX, 5'd21, 5'd10, 8'h00, 8'h00, 8'h00);
        push_palette_op(OP_MIX, 5'd21, 5'd2, 8'hff, 8'h00, 8'hff);
        push_palette_op(OP_MIX, 5'd31, 5'd21, 8'h00, 8'hff, 8'h00);

        // --- random part ---
        for (int n = 0; n < RANDOM_OPS; n++) begin
            quiet_stretch <= (n >= 700 && n < 1100);
            sel = $urandom_range(99);
            ia  = IDX_W'($urandom_range(PALETTE_SIZE - 1));
            ib  = IDX_W'($urandom_range(PALETTE_SIZE - 1));
            c   = '{r: pick_channel(), g: pick_channel(), b: pick_channel()};
            if (sel < 30) begin
                // a quarter of writes copy a stored color so ties keep turning up
                if ($urandom_range(3) == 0) begin
                    k = int'(pick_written_entry());
                    if (palette_model.palette_written[k])
                        c = palette_model.palette_colors[k];
                end
                push_palette_op(OP_WRITE, ia, ib, c.r, c.g, c.b);
            end
            else if (sel < 65) begin
                // some queries land exactly on a stored color
                if ($urandom_range(4) == 0) begin
                    k = int'(pick_written_entry());
                    if (palette_model.palette_written[k])
                        c = palette_model.palette_colors[k];
                end
                push_palette_op(OP_QUERY, ia, ib, c.r, c.g, c.b);
            end
            else if (sel < 95) begin
                // mostly well-formed mixes, the rest name arbitrary entries
                if ($urandom_range(4) != 0) begin
                    ia = pick_written_entry();
                    ib = pick_written_entry();
                end
                push_palette_op(OP_MIX, ia, ib, c.r, c.g, c.b);
            end
            else begin
                push_palette_op(OP_UNUSED, ia, ib, c.r, c.g, c.b);
            end
        end

        in_valid <= 1'b0;
        quiet_stretch <= 1'b0;
        while (palette_model.pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (palette_model.fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
